// File: rtl/core/bcpg_pkg.sv
// ----------------------------------------------------------------------------
// bcpg_pkg
// Shared types and constants of the Bezier curve point generator.
// ----------------------------------------------------------------------------
package bcpg_pkg;

   // Control point counts that select a curve.
   localparam logic [2:0] CNT_QUAD  = 3'd3;
   localparam logic [2:0] CNT_CUBIC = 3'd4;

   // Result coordinates are in sixteenths of a pixel.
   localparam int OUT_BITS = 16;
   // Rounding works on 32*num + den over 2*den, so the numerator moves up five bits.
   localparam int ROUND_SHIFT = 5;

   typedef struct packed {
      logic valid;
      logic last;
      logic cubic;
   } bcpg_ctl_type;

endpackage

// File: rtl/core/bcpg_if.sv
// ----------------------------------------------------------------------------
// bcpg request and response channels
// Valid/ready channels that carry control points in and curve points out.
// ----------------------------------------------------------------------------
interface bcpg_req_if #(
   parameter int COORD_BITS = 12
) ();
   logic                  valid;
   logic                  ready;
   logic [2:0]            point_count;
   logic [COORD_BITS-1:0] p0_x;
   logic [COORD_BITS-1:0] p0_y;
   logic [COORD_BITS-1:0] p1_x;
   logic [COORD_BITS-1:0] p1_y;
   logic [COORD_BITS-1:0] p2_x;
   logic [COORD_BITS-1:0] p2_y;
   logic [COORD_BITS-1:0] p3_x;
   logic [COORD_BITS-1:0] p3_y;

   modport source (output valid, point_count, p0_x, p0_y, p1_x, p1_y, p2_x, p2_y,
                   p3_x, p3_y, input ready);
   modport sink   (input valid, point_count, p0_x, p0_y, p1_x, p1_y, p2_x, p2_y,
                   p3_x, p3_y, output ready);
endinterface

interface bcpg_rsp_if ();
   import bcpg_pkg::*;

   logic                valid;
   logic                ready;
   logic [OUT_BITS-1:0] curve_x;
   logic [OUT_BITS-1:0] curve_y;
   logic                last_point;

   modport source (output valid, curve_x, curve_y, last_point, input ready);
   modport sink   (input valid, curve_x, curve_y, last_point, output ready);
endinterface

// File: rtl/core/bcpg_seq.sv
// ----------------------------------------------------------------------------
// bcpg_seq
// Holds the current request and steps the curve index from zero to STEPS.
// ----------------------------------------------------------------------------
module bcpg_seq #(
   parameter int STEPS      = 30,
   parameter int COORD_BITS = 12,
   parameter int IW         = 5
) (
   input  logic                               clock,
   input  logic                               reset,
   input  logic                               adv,
   bcpg_req_if.sink                           req,
   output bcpg_pkg::bcpg_ctl_type             ctl,
   output logic [IW-1:0]                      idx,
   output logic [3:0][COORD_BITS-1:0]         xs,
   output logic [3:0][COORD_BITS-1:0]         ys
);
   import bcpg_pkg::*;

   logic                       busy_ff, busy_in;
   logic [IW-1:0]              idx_ff, idx_in;
   logic                       cubic_ff, cubic_in;
   logic [3:0][COORD_BITS-1:0] xs_ff, ys_ff;
   logic                       is_last;
   logic                       accept;
   logic                       good;

   always_comb begin
      is_last   = busy_ff && (idx_ff == IW'(STEPS));
      // A new request loads as soon as the last index of the current one moves on.
      req.ready = !busy_ff || (adv && is_last);
      accept    = req.valid && req.ready;
      good      = (req.point_count == CNT_QUAD) || (req.point_count == CNT_CUBIC);
      busy_in   = busy_ff;
      idx_in    = idx_ff;
      cubic_in  = cubic_ff;
      if (accept) begin
         busy_in  = good;
         idx_in   = '0;
         cubic_in = (req.point_count == CNT_CUBIC);
      end else if (busy_ff && adv) begin
         if (is_last) begin
            busy_in = 1'b0;
         end else begin
            idx_in = idx_ff + IW'(1);
         end
      end
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         busy_ff <= 1'b0;
      end else begin
         busy_ff <= busy_in;
      end
   end

   always_ff @(posedge clock) begin
      idx_ff   <= idx_in;
      cubic_ff <= cubic_in;
      if (accept) begin
         xs_ff <= {req.p3_x, req.p2_x, req.p1_x, req.p0_x};
         ys_ff <= {req.p3_y, req.p2_y, req.p1_y, req.p0_y};
      end
   end

   always_comb begin
      ctl.valid = busy_ff;
      ctl.last  = is_last;
      ctl.cubic = cubic_ff;
      idx       = idx_ff;
      xs        = xs_ff;
      ys        = ys_ff;
   end

endmodule

// File: rtl/core/bcpg_mac.sv
// ----------------------------------------------------------------------------
// bcpg_mac
// Bernstein weights for one index, weighted sums of the control points.
// ----------------------------------------------------------------------------
module bcpg_mac #(
   parameter int STEPS      = 30,
   parameter int COORD_BITS = 12,
   parameter int IW         = 5,
   parameter int PW         = 27
) (
   input  logic                       clock,
   input  logic                       reset,
   input  logic                       adv,
   input  bcpg_pkg::bcpg_ctl_type     ctl_in,
   input  logic [IW-1:0]              idx,
   input  logic [3:0][COORD_BITS-1:0] xs,
   input  logic [3:0][COORD_BITS-1:0] ys,
   output bcpg_pkg::bcpg_ctl_type     ctl_out,
   output logic [PW-1:0]              num_x,
   output logic [PW-1:0]              num_y
);
   import bcpg_pkg::*;

   localparam int DW = $clog2(STEPS * STEPS * STEPS + 1);
   localparam int EW = 3 * IW + 2;
   localparam logic [EW-1:0] S_E     = EW'(STEPS);
   localparam logic [EW-1:0] TWO_S_E = EW'(2 * STEPS);
   localparam logic [EW-1:0] THREE_E = EW'(3);

   bcpg_ctl_type               ctl1_ff, ctl2_ff, ctl3_ff, ctl4_ff;
   logic [IW-1:0]              u1_ff, i1_ff;
   logic [2*IW-1:0]            u2_ff, ui_ff, i2_ff;
   logic [3:0][COORD_BITS-1:0] xs1_ff, ys1_ff, xs2_ff, ys2_ff;
   logic [3:0][DW-1:0]         w_ff, w_in;
   logic [3:0][PW-1:0]         px_ff, py_ff;
   logic [PW-1:0]              numx_ff, numy_ff;
   logic [IW-1:0]              u;
   logic [EW-1:0]              e0, e1, e2, e3;

   assign u = IW'(STEPS) - idx;

   // The quadratic weights are scaled by STEPS so both curves share the cube denominator.
   always_comb begin
      if (ctl1_ff.cubic) begin
         e0 = EW'(u2_ff) * EW'(u1_ff);
         e1 = THREE_E * EW'(u2_ff) * EW'(i1_ff);
         e2 = THREE_E * EW'(u1_ff) * EW'(i2_ff);
         e3 = EW'(i2_ff) * EW'(i1_ff);
      end else begin
         e0 = S_E * EW'(u2_ff);
         e1 = TWO_S_E * EW'(ui_ff);
         e2 = S_E * EW'(i2_ff);
         e3 = '0;
      end
      w_in[0] = DW'(e0);
      w_in[1] = DW'(e1);
      w_in[2] = DW'(e2);
      w_in[3] = DW'(e3);
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         ctl1_ff.valid <= 1'b0;
         ctl2_ff.valid <= 1'b0;
         ctl3_ff.valid <= 1'b0;
         ctl4_ff.valid <= 1'b0;
      end else if (adv) begin
         ctl1_ff <= ctl_in;
         ctl2_ff <= ctl1_ff;
         ctl3_ff <= ctl2_ff;
         ctl4_ff <= ctl3_ff;
      end
   end

   always_ff @(posedge clock) begin
      if (adv) begin
         u1_ff  <= u;
         i1_ff  <= idx;
         u2_ff  <= (2*IW)'(u) * (2*IW)'(u);
         ui_ff  <= (2*IW)'(u) * (2*IW)'(idx);
         i2_ff  <= (2*IW)'(idx) * (2*IW)'(idx);
         xs1_ff <= xs;
         ys1_ff <= ys;

         w_ff   <= w_in;
         xs2_ff <= xs1_ff;
         ys2_ff <= ys1_ff;

         for (int k = 0; k < 4; k++) begin
            px_ff[k] <= PW'(w_ff[k]) * PW'(xs2_ff[k]);
            py_ff[k] <= PW'(w_ff[k]) * PW'(ys2_ff[k]);
         end

         numx_ff <= px_ff[0] + px_ff[1] + px_ff[2] + px_ff[3];
         numy_ff <= py_ff[0] + py_ff[1] + py_ff[2] + py_ff[3];
      end
   end

   assign ctl_out = ctl4_ff;
   assign num_x   = numx_ff;
   assign num_y   = numy_ff;

endmodule

// File: rtl/core/bcpg_div.sv
// ----------------------------------------------------------------------------
// bcpg_div
// Rounds both weighted sums to sixteenths of a pixel: a saturation check, then
// division by the constant denominator as a multiplication by its rounded-up
// reciprocal, split into four narrow partial products over two stages.
// ----------------------------------------------------------------------------
module bcpg_div #(
   parameter int STEPS      = 30,
   parameter int COORD_BITS = 12,
   parameter int PW         = 27
) (
   input  logic                                   clock,
   input  logic                                   reset,
   input  logic                                   adv,
   input  bcpg_pkg::bcpg_ctl_type                 ctl_in,
   input  logic [1:0][PW-1:0]                     num,
   output bcpg_pkg::bcpg_ctl_type                 ctl_out,
   output logic [1:0][bcpg_pkg::OUT_BITS-1:0]     val
);
   import bcpg_pkg::*;

   localparam int QB   = OUT_BITS;
   localparam int CUBE = STEPS * STEPS * STEPS;
   localparam int DW   = $clog2(CUBE + 1);
   localparam int RW   = DW + ((COORD_BITS + ROUND_SHIFT > QB + 1) ?
                               COORD_BITS + ROUND_SHIFT : QB + 1);
   localparam logic [RW-1:0] DEN     = RW'(CUBE);
   // Quotients of 2^16 and up clamp to all ones.
   localparam logic [RW-1:0] SAT_LIM = DEN << (QB + 1);
   // With RW plus clog2(2*DEN) fraction bits, the rounded-up reciprocal gives
   // the exact floor quotient for every RW-bit dividend.
   localparam longint unsigned DEN2  = 64'(2 * CUBE);
   localparam int              FB    = RW + $clog2(DEN2);
   localparam longint unsigned RECIP = ((64'd1 << FB) + DEN2 - 64'd1) / DEN2;
   localparam int              MB    = $clog2(RECIP + 64'd1);
   localparam int              PRW   = RW + MB;
   localparam int              NL    = RW / 2;
   localparam int              NH    = RW - NL;
   localparam int              ML    = MB / 2;
   localparam int              MH    = MB - ML;
   localparam logic [ML-1:0]   R_LO  = ML'(RECIP);
   localparam logic [MH-1:0]   R_HI  = MH'(RECIP >> ML);

   bcpg_ctl_type     ctl0_ff, ctl1_ff, ctl2_ff;
   logic [RW-1:0]    n0_ff   [2];
   logic             sat0_ff [2];
   logic             sat1_ff [2];
   logic [NL+ML-1:0] pll_ff  [2];
   logic [NL+MH-1:0] plh_ff  [2];
   logic [NH+ML-1:0] phl_ff  [2];
   logic [NH+MH-1:0] phh_ff  [2];
   logic [QB-1:0]    q_ff    [2];
   logic [RW-1:0]    n       [2];
   logic             sat     [2];
   logic [PRW-1:0]   prod    [2];

   always_comb begin
      for (int l = 0; l < 2; l++) begin
         n[l]    = (RW'(num[l]) << ROUND_SHIFT) + DEN;
         sat[l]  = (n[l] >= SAT_LIM);
         prod[l] = PRW'(pll_ff[l]) + (PRW'(plh_ff[l]) << ML)
                 + (PRW'(phl_ff[l]) << NL) + (PRW'(phh_ff[l]) << (NL + ML));
         val[l]  = q_ff[l];
      end
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         ctl0_ff.valid <= 1'b0;
         ctl1_ff.valid <= 1'b0;
         ctl2_ff.valid <= 1'b0;
      end else if (adv) begin
         ctl0_ff <= ctl_in;
         ctl1_ff <= ctl0_ff;
         ctl2_ff <= ctl1_ff;
      end
   end

   // A saturated value skips the quotient and comes out as all ones.
   always_ff @(posedge clock) begin
      if (adv) begin
         for (int l = 0; l < 2; l++) begin
            n0_ff[l]   <= n[l];
            sat0_ff[l] <= sat[l];
            pll_ff[l]  <= (NL+ML)'(n0_ff[l][NL-1:0]) * (NL+ML)'(R_LO);
            plh_ff[l]  <= (NL+MH)'(n0_ff[l][NL-1:0]) * (NL+MH)'(R_HI);
            phl_ff[l]  <= (NH+ML)'(n0_ff[l][RW-1:NL]) * (NH+ML)'(R_LO);
            phh_ff[l]  <= (NH+MH)'(n0_ff[l][RW-1:NL]) * (NH+MH)'(R_HI);
            sat1_ff[l] <= sat0_ff[l];
            q_ff[l]    <= sat1_ff[l] ? '1 : prod[l][FB +: QB];
         end
      end
   end

   assign ctl_out = ctl2_ff;

endmodule

// File: rtl/core/bezier_curve_point_generator.sv
// ----------------------------------------------------------------------------
// Bezier curve point generator
// A request beat carries four control points and a count. Count four gives the
// cubic curve, count three the quadratic one, each as STEPS+1 points at
// t = i/STEPS ending exactly at t = 1, in sixteenths of a pixel rounded half
// up and clamped at 65535; the last point of a run has last_point set. Any
// other count is taken and gives no points. The index counter issues one
// point per cycle while the response does not stall, and the next request
// is taken in the cycle its last index issues; points stream out back to
// back. After its index issues, a point passes through four weight and sum
// stages, a rounding stage, a partial product stage and a final sum stage.
// A stall on the response holds the whole pipeline.
// ----------------------------------------------------------------------------
module bezier_curve_point_generator #(
   parameter int STEPS      = 30,
   parameter int COORD_BITS = 12
) (
   input  logic        clock,
   input  logic        reset,
   bcpg_req_if.sink    req_bus,
   bcpg_rsp_if.source  rsp_bus
);
   import bcpg_pkg::*;

   localparam int IW = $clog2(STEPS + 1);
   localparam int DW = $clog2(STEPS * STEPS * STEPS + 1);
   localparam int PW = DW + COORD_BITS;

   logic                       adv;
   bcpg_ctl_type               s_ctl, m_ctl, d_ctl;
   logic [IW-1:0]              s_idx;
   logic [3:0][COORD_BITS-1:0] s_xs, s_ys;
   logic [PW-1:0]              m_num_x, m_num_y;
   logic [1:0][OUT_BITS-1:0]   d_val;

   assign adv = !rsp_bus.valid || rsp_bus.ready;

   bcpg_seq #(
      .STEPS      (STEPS),
      .COORD_BITS (COORD_BITS),
      .IW         (IW)
   ) u_seq (
      .clock (clock),
      .reset (reset),
      .adv   (adv),
      .req   (req_bus),
      .ctl   (s_ctl),
      .idx   (s_idx),
      .xs    (s_xs),
      .ys    (s_ys)
   );

   bcpg_mac #(
      .STEPS      (STEPS),
      .COORD_BITS (COORD_BITS),
      .IW         (IW),
      .PW         (PW)
   ) u_mac (
      .clock   (clock),
      .reset   (reset),
      .adv     (adv),
      .ctl_in  (s_ctl),
      .idx     (s_idx),
      .xs      (s_xs),
      .ys      (s_ys),
      .ctl_out (m_ctl),
      .num_x   (m_num_x),
      .num_y   (m_num_y)
   );

   bcpg_div #(
      .STEPS      (STEPS),
      .COORD_BITS (COORD_BITS),
      .PW         (PW)
   ) u_div (
      .clock   (clock),
      .reset   (reset),
      .adv     (adv),
      .ctl_in  (m_ctl),
      .num     ({m_num_y, m_num_x}),
      .ctl_out (d_ctl),
      .val     (d_val)
   );

   assign rsp_bus.valid      = d_ctl.valid;
   assign rsp_bus.curve_x    = d_val[0];
   assign rsp_bus.curve_y    = d_val[1];
   assign rsp_bus.last_point = d_ctl.last;

`ifndef SYNTHESIS
   // A curve request starts its run at index zero in the next cycle.
   a_start: assert property (@(posedge clock) disable iff (reset)
      (req_bus.valid && req_bus.ready &&
       (req_bus.point_count == CNT_QUAD || req_bus.point_count == CNT_CUBIC))
      |=> (s_ctl.valid && s_idx == '0))
      else $error("curve run did not start at index zero");

   // While a run is in progress, a new request is only taken as its last index leaves.
   a_overlap: assert property (@(posedge clock) disable iff (reset)
      (s_ctl.valid && req_bus.ready) |-> (s_ctl.last && adv))
      else $error("request taken in the middle of a run");

   // Nothing comes out right after reset.
   a_reset: assert property (@(posedge clock)
      reset |=> !rsp_bus.valid)
      else $error("response valid after reset");
`endif

endmodule

// File: verif/bezier_curve_point_generator_test.sv
// ----------------------------------------------------------------------------
// Bezier curve point generator testbench
// Sends quadratic, cubic and non-curve requests and checks every curve point
// against an exact integer Bernstein evaluation with half-up rounding or
// a fixed flat value. A short table of directed requests comes first, then
// random requests under three idling mixes and one long response stall.
// ----------------------------------------------------------------------------
module bezier_curve_point_generator_test;
   timeunit 1ns;
   timeprecision 1ps;

   import bcpg_pkg::*;

   localparam int STEPS      = 30;
   localparam int COORD_BITS = 12;
   localparam int RANDOM_CURVES = 180;
   localparam int DRAIN_CYCLES  = 40;
   localparam int HOLD_CYCLES   = 400;
   localparam longint unsigned OUT_MAX = (longint'(1) << OUT_BITS) - 1;

   typedef logic [COORD_BITS-1:0] coord_type;
   typedef logic [OUT_BITS-1:0]   outc_type;

   typedef struct packed {
      logic [2:0] point_count;
      coord_type  p0_x;
      coord_type  p0_y;
      coord_type  p1_x;
      coord_type  p1_y;
      coord_type  p2_x;
      coord_type  p2_y;
      coord_type  p3_x;
      coord_type  p3_y;
   } curve_req_type;

   typedef struct packed {
      outc_type x;
      outc_type y;
      logic     last;
   } curve_pt_type;

   // How the expected points of a table row are obtained.
   typedef enum {EXP_MODEL, EXP_FLAT, EXP_NONE} plan_type;

   typedef struct {
      curve_req_type req;
      plan_type      plan;
      outc_type      flat_x;
      outc_type      flat_y;
   } directed_row_type;

   logic clock = 1'b0;
   logic reset = 1'b1;

   always #2 clock = ~clock;

   bcpg_req_if #(.COORD_BITS(COORD_BITS)) req_bus ();
   bcpg_rsp_if rsp_bus ();

   bezier_curve_point_generator #(
      .STEPS      (STEPS),
      .COORD_BITS (COORD_BITS)
   ) u_top (
      .clock   (clock),
      .reset   (reset),
      .req_bus (req_bus),
      .rsp_bus (rsp_bus)
   );

   curve_pt_type     points_due[$];
   directed_row_type directed_rows[$];
   int unsigned      mismatch_count = 0;
   int unsigned      sender_idle_pct = 0;
   int unsigned      recv_idle_pct = 0;
   logic             hold_armed = 1'b0;

   // One coordinate of the curve at t = i/STEPS, in sixteenths of a pixel.
   function automatic outc_type bezier_coord(bit cubic, int unsigned i,
                                             coord_type c0, coord_type c1,
                                             coord_type c2, coord_type c3);
      longint unsigned u, t, sum, den, v;
      u = STEPS - i;
      t = i;
      if (cubic) begin
         sum = u * u * u * c0 + 3 * u * u * t * c1 + 3 * u * t * t * c2 + t * t * t * c3;
         den = STEPS * STEPS * STEPS;
      end else begin
         sum = u * u * c0 + 2 * u * t * c1 + t * t * c2;
         den = STEPS * STEPS;
      end
      v = (32 * sum + den) / (2 * den);
      return (v > OUT_MAX) ? outc_type'(OUT_MAX) : outc_type'(v);
   endfunction

   function automatic void queue_curve_points(curve_req_type r, plan_type plan,
                                              outc_type flat_x, outc_type flat_y);
      curve_pt_type pt;
      bit           cubic;
      if (plan == EXP_NONE) return;
      if (plan == EXP_MODEL && r.point_count != CNT_QUAD && r.point_count != CNT_CUBIC)
         return;
      cubic = (r.point_count == CNT_CUBIC);
      for (int unsigned i = 0; i <= STEPS; i++) begin
         if (plan == EXP_FLAT) begin
            pt.x = flat_x;
            pt.y = flat_y;
         end else begin
            pt.x = bezier_coord(cubic, i, r.p0_x, r.p1_x, r.p2_x, r.p3_x);
            pt.y = bezier_coord(cubic, i, r.p0_y, r.p1_y, r.p2_y, r.p3_y);
         end
         pt.last = (i == STEPS);
         points_due.push_back(pt);
      end
   endfunction

   function automatic void add_row(logic [2:0] cnt, int x0, int y0, int x1, int y1,
                                   int x2, int y2, int x3, int y3,
                                   plan_type plan, int fx = 0, int fy = 0);
      directed_row_type row;
      row.req = '{cnt, coord_type'(x0), coord_type'(y0), coord_type'(x1), coord_type'(y1),
                  coord_type'(x2), coord_type'(y2), coord_type'(x3), coord_type'(y3)};
      row.plan   = plan;
      row.flat_x = outc_type'(fx);
      row.flat_y = outc_type'(fy);
      directed_rows.push_back(row);
   endfunction

   function automatic coord_type pick_coord();
      case ($urandom_range(7))
         0: return '0;
         1: return '1;
         default: return coord_type'($urandom_range((1 << COORD_BITS) - 1));
      endcase
   endfunction

   function automatic void report_mismatch(string what, curve_pt_type want,
                                           curve_pt_type got);
      mismatch_count++;
      if (mismatch_count <= 10)
         $display("%0t: %s: expected x=%0d y=%0d last=%0d, got x=%0d y=%0d last=%0d",
                  $realtime, what, want.x, want.y, want.last, got.x, got.y, got.last);
   endfunction

   // The valid of the previous beat stays high unless an idle gap is taken, so
   // valid is never lowered and raised within one edge.
   task automatic offer_request(curve_req_type r, plan_type plan,
                                outc_type flat_x, outc_type flat_y);
      while ($urandom_range(99) < sender_idle_pct) begin
         req_bus.valid <= 1'b0;
         @(posedge clock);
      end
      req_bus.valid       <= 1'b1;
      req_bus.point_count <= r.point_count;
      req_bus.p0_x        <= r.p0_x;
      req_bus.p0_y        <= r.p0_y;
      req_bus.p1_x        <= r.p1_x;
      req_bus.p1_y        <= r.p1_y;
      req_bus.p2_x        <= r.p2_x;
      req_bus.p2_y        <= r.p2_y;
      req_bus.p3_x        <= r.p3_x;
      req_bus.p3_y        <= r.p3_y;
      do @(posedge clock); while (req_bus.ready !== 1'b1);
      queue_curve_points(r, plan, flat_x, flat_y);
   endtask

   // Response side: random back-pressure, plus one long hold once armed.
   initial begin : response_drive
      int unsigned hold_left;
      bit          hold_done;
      hold_left = 0;
      hold_done = 1'b0;
      rsp_bus.ready <= 1'b0;
      forever begin
         @(posedge clock);
         if (hold_left != 0) begin
            hold_left--;
            rsp_bus.ready <= 1'b0;
         end else if (hold_armed && !hold_done) begin
            hold_done = 1'b1;
            hold_left = HOLD_CYCLES;
            rsp_bus.ready <= 1'b0;
         end else begin
            rsp_bus.ready <= ($urandom_range(99) >= recv_idle_pct);
         end
      end
   end

   always @(posedge clock) begin : point_check
      curve_pt_type got, want;
      if (!reset && rsp_bus.valid === 1'b1 && rsp_bus.ready === 1'b1) begin
         got.x    = rsp_bus.curve_x;
         got.y    = rsp_bus.curve_y;
         got.last = rsp_bus.last_point;
         if (points_due.size() == 0) begin
            report_mismatch("unexpected point", '0, got);
         end else begin
            want = points_due.pop_front();
            if (got.x !== want.x || got.y !== want.y || got.last !== want.last)
               report_mismatch("point mismatch", want, got);
         end
      end
   end

   initial begin : stimulus
      curve_req_type r;
      int unsigned   curves_sent;
      int unsigned   pick;

      req_bus.valid       <= 1'b0;
      req_bus.point_count <= '0;
      req_bus.p0_x        <= '0;
      req_bus.p0_y        <= '0;
      req_bus.p1_x        <= '0;
      req_bus.p1_y        <= '0;
      req_bus.p2_x        <= '0;
      req_bus.p2_y        <= '0;
      req_bus.p3_x        <= '0;
      req_bus.p3_y        <= '0;

      // Flat curves land exactly on the control point, times sixteen.
      add_row(CNT_CUBIC, 0, 0, 0, 0, 0, 0, 0, 0, EXP_FLAT, 0, 0);
      add_row(CNT_CUBIC, 4095, 4095, 4095, 4095, 4095, 4095, 4095, 4095,
              EXP_FLAT, 65520, 65520);
      // The fourth point must not leak into a quadratic curve.
      add_row(CNT_QUAD, 4095, 4095, 4095, 4095, 4095, 4095, 0, 0, EXP_FLAT, 65520, 65520);
      add_row(CNT_QUAD, 0, 0, 0, 0, 0, 0, 4095, 4095, EXP_FLAT, 0, 0);
      // Counts that select no curve produce no points at all.
      add_row(3'd0, 4095, 4095, 4095, 4095, 4095, 4095, 4095, 4095, EXP_NONE);
      add_row(3'd1, 'hAAA, 'h555, 'hAAA, 'h555, 'hAAA, 'h555, 'hAAA, 'h555, EXP_NONE);
      add_row(3'd2, 'h555, 'hAAA, 'h555, 'hAAA, 'h555, 'hAAA, 'h555, 'hAAA, EXP_NONE);
      add_row(3'd5, 4095, 0, 4095, 0, 4095, 0, 4095, 0, EXP_NONE);
      add_row(3'd6, 0, 4095, 0, 4095, 0, 4095, 0, 4095, EXP_NONE);
      add_row(3'd7, 4095, 4095, 4095, 4095, 4095, 4095, 4095, 4095, EXP_NONE);
      add_row(CNT_CUBIC, 0, 4095, 4095, 0, 0, 4095, 4095, 0, EXP_MODEL);
      add_row(CNT_QUAD, 0, 4095, 4095, 4095, 4095, 0, 'hAAA, 'h555, EXP_MODEL);
      add_row(CNT_CUBIC, 'hAAA, 'h555, 'h555, 'hAAA, 'hAAA, 'h555, 'h555, 'hAAA, EXP_MODEL);
      add_row(CNT_QUAD, 'h555, 'hAAA, 'hAAA, 'h555, 'h555, 'hAAA, 4095, 4095, EXP_MODEL);
      add_row(CNT_CUBIC, 4095, 4095, 0, 0, 0, 0, 0, 0, EXP_MODEL);
      add_row(CNT_CUBIC, 0, 0, 0, 0, 0, 0, 4095, 4095, EXP_MODEL);
      add_row(CNT_QUAD, 0, 0, 4095, 4095, 0, 0, 0, 0, EXP_MODEL);
      // Small coordinates put many points right at a rounding boundary.
      add_row(CNT_QUAD, 1, 3, 2, 2, 3, 1, 0, 0, EXP_MODEL);
      add_row(CNT_CUBIC, 1, 0, 0, 1, 0, 0, 0, 1, EXP_MODEL);

      sender_idle_pct = 17;
      recv_idle_pct   = 67;
      repeat (10) @(posedge clock);
      reset <= 1'b0;

      foreach (directed_rows[n])
         offer_request(directed_rows[n].req, directed_rows[n].plan,
                       directed_rows[n].flat_x, directed_rows[n].flat_y);

      curves_sent = 0;
      while (curves_sent < RANDOM_CURVES) begin
         if (curves_sent == RANDOM_CURVES / 3) begin
            sender_idle_pct = 67;
            recv_idle_pct   = 17;
         end else if (curves_sent == 2 * RANDOM_CURVES / 3) begin
            sender_idle_pct = 0;
            recv_idle_pct   = 0;
            hold_armed <= 1'b1;
         end
         pick = $urandom_range(99);
         if (pick < 45)
            r.point_count = CNT_CUBIC;
         else if (pick < 85)
            r.point_count = CNT_QUAD;
         else
            r.point_count = 3'($urandom_range(7));
         r.p0_x = pick_coord();
         r.p0_y = pick_coord();
         r.p1_x = pick_coord();
         r.p1_y = pick_coord();
         r.p2_x = pick_coord();
         r.p2_y = pick_coord();
         r.p3_x = pick_coord();
         r.p3_y = pick_coord();
         offer_request(r, EXP_MODEL, '0, '0);
         if (r.point_count == CNT_CUBIC || r.point_count == CNT_QUAD)
            curves_sent++;
      end
      req_bus.valid <= 1'b0;

      while (points_due.size() != 0) @(posedge clock);
      repeat (DRAIN_CYCLES) @(posedge clock);
      if (mismatch_count == 0) begin
         $display("[ OK ] regression clean");
      end else begin
         $display("[FAIL] regression broken");
      end
      $finish;
   end

   // Far beyond the slowest correct run: every point waiting on a mostly idle
   // receiver, plus the long hold.
   initial begin : watchdog
      #2_000_000;
      $display("[FAIL] regression broken");
      $finish;
   end

endmodule
